// ===== rtl/hdcf_pkg.sv =====
// ----------------------------------------------------------------------------
// hdcf_pkg
// shared constants and types of the hot and dead channel finder
// ----------------------------------------------------------------------------
package hdcf_pkg;

  localparam int NumChannelsDef = 24576;
  localparam int BlockSizeDef   = 64;
  localparam int SectorSizeDef  = 384;
  localparam int CountBitsDef   = 20;

  localparam int ChannelW  = 15;
  localparam int EnergyW   = 18;
  localparam int FractionW = 16;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 18;

  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_END_EVT  = 2'd1,
    KIND_EVALUATE = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  localparam logic [CfgAddrW-1:0] REG_THR0  = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_THR1  = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_FRAC0 = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_FRAC1 = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_FRACR = 3'd4;

  typedef struct packed {
    logic [ChannelW-1:0] channel;
    logic                hot_now;
    logic                dead_now;
    logic                block_hot;
    logic                sector_hot;
    logic                ever_hot;
    logic                ever_dead;
    logic                any_region_hot;
  } result_t;

  typedef struct packed {
    logic signed [EnergyW-1:0] thr0;
    logic signed [EnergyW-1:0] thr1;
    logic [FractionW-1:0]      frac0;
    logic [FractionW-1:0]      frac1;
    logic [FractionW-1:0]      fracr;
  } cfg_t;

endpackage

// ===== rtl/hdcf_if.sv =====
// ----------------------------------------------------------------------------
// hdcf_in_if / hdcf_out_if
// valid/ready channels of the hot and dead channel finder
// ----------------------------------------------------------------------------
interface hdcf_in_if;
  import hdcf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [ChannelW-1:0]       channel;
  logic                      fiber;
  logic signed [EnergyW-1:0] energy;
  modport source (output valid, kind, channel, fiber, energy, input ready);
  modport sink   (input valid, kind, channel, fiber, energy, output ready);
endinterface

interface hdcf_out_if;
  import hdcf_pkg::*;
  logic                valid;
  logic                ready;
  logic [ChannelW-1:0] result_channel;
  logic                hot_now;
  logic                dead_now;
  logic                block_hot;
  logic                sector_hot;
  logic                ever_hot;
  logic                ever_dead;
  logic                any_region_hot;
  modport source (output valid, result_channel, hot_now, dead_now, block_hot,
                  sector_hot, ever_hot, ever_dead, any_region_hot, input ready);
  modport sink   (input valid, result_channel, hot_now, dead_now, block_hot,
                  sector_hot, ever_hot, ever_dead, any_region_hot, output ready);
endinterface

// ===== rtl/hdcf_cfg.sv =====
// ----------------------------------------------------------------------------
// hdcf_cfg
// configuration register file
// ----------------------------------------------------------------------------
module hdcf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [hdcf_pkg::CfgAddrW-1:0] wr_index,
  input  logic [hdcf_pkg::CfgDataW-1:0] wr_data,
  output hdcf_pkg::cfg_t                cfg
);
  import hdcf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr0  <= '0;
      cfg.thr1  <= '0;
      cfg.frac0 <= 16'h8000;
      cfg.frac1 <= 16'h8000;
      cfg.fracr <= 16'h8000;
    end else if (wr_en) begin
      case (wr_index)
        REG_THR0:  cfg.thr0  <= wr_data;
        REG_THR1:  cfg.thr1  <= wr_data;
        REG_FRAC0: cfg.frac0 <= wr_data[FractionW-1:0];
        REG_FRAC1: cfg.frac1 <= wr_data[FractionW-1:0];
        REG_FRACR: cfg.fracr <= wr_data[FractionW-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/hdcf_counter_ram.sv =====
// ----------------------------------------------------------------------------
// hdcf_counter_ram
// single-port-write, one-read synchronous counter memory with epoch tags
// ----------------------------------------------------------------------------
module hdcf_counter_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 20,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/hot_dead_channel_finder.sv =====
// ----------------------------------------------------------------------------
// hot_dead_channel_finder
// occupancy based hot and dead channel finder
// ----------------------------------------------------------------------------
// Items arrive on in_ch (kind, channel, fiber, energy); each evaluate
// item for a channel in range gives one word on out_ch. The user must write
// config on cfg_wr_en / cfg_index / cfg_data only while idle; the block
// does not enforce it. Every item passes through the steps accept, memory
// read, compare and read-modify-write back, then release. The rate is set by
// the single read-then-write pass through the counter and mark memories.
// A word is loaded into the output register at the end of the compare step
// and leaves once out_ch.ready is high. While out_ch.ready is low the word
// holds there and later items go on; only the next in-range evaluate waits
// in its compare cycle until the word has left.
// Clear run bumps a run epoch; each counter entry carries the epoch it was
// last written in, so stale entries read as zero and no sweep is needed.
// When the epoch wraps, a sweep zeroes all counts but keeps the sticky marks.
// After reset a clearing pass zeroes all memories, one channel a cycle; no item
// is taken then but config writes are.
// ----------------------------------------------------------------------------
module hot_dead_channel_finder #(
  parameter int NUM_CHANNELS = hdcf_pkg::NumChannelsDef,
  parameter int BLOCK_SIZE   = hdcf_pkg::BlockSizeDef,
  parameter int SECTOR_SIZE  = hdcf_pkg::SectorSizeDef,
  parameter int COUNT_BITS   = hdcf_pkg::CountBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  hdcf_in_if.sink                       in_ch,
  hdcf_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [hdcf_pkg::CfgAddrW-1:0] cfg_index,
  input  logic [hdcf_pkg::CfgDataW-1:0] cfg_data
);
  import hdcf_pkg::*;

  localparam int NumBlocks  = (NUM_CHANNELS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int NumSectors = (NUM_CHANNELS + SECTOR_SIZE - 1) / SECTOR_SIZE;
  localparam int ChAW  = $clog2(NUM_CHANNELS);
  localparam int BlkAW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int SecAW = (NumSectors > 1) ? $clog2(NumSectors) : 1;
  localparam int EpW   = 8;
  // entry word: epoch, count (sticky marks ride on channel entries)
  localparam int CntEntW = EpW + COUNT_BITS;
  localparam int ChEntW  = CntEntW + 2;
  localparam int IdxW    = ChAW + 1;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  // block and sector index by reciprocal multiplication, exact over the field
  localparam int ProdW    = 2 * ChannelW + 1;
  localparam int BlkShift = ChannelW + $clog2(BLOCK_SIZE);
  localparam int SecShift = ChannelW + $clog2(SECTOR_SIZE);
  localparam logic [ChannelW:0] BlkMul = (ChannelW + 1)'(
    ((64'd1 << BlkShift) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE));
  localparam logic [ChannelW:0] SecMul = (ChannelW + 1)'(
    ((64'd1 << SecShift) + 64'(SECTOR_SIZE) - 64'd1) / 64'(SECTOR_SIZE));

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_READ = 5'b00100,
    S_MOD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  cfg_t   cfg;

  hdcf_cfg u_cfg (
    .clk(clk), .rst(rst), .wr_en(cfg_wr_en), .wr_index(cfg_index),
    .wr_data(cfg_data), .cfg(cfg)
  );

  logic [IdxW-1:0]       init_cnt;
  logic [IdxW-1:0]       init_wr;
  logic                  sweep_keep;
  logic [1:0]            kind;
  logic [ChannelW-1:0]   channel;
  logic                  ftype;
  logic signed [EnergyW-1:0] energy;
  logic [EpW-1:0]        epoch;
  logic [COUNT_BITS-1:0] good_events;
  logic                  event_is_good;
  logic                  region_seen_hot;
  result_t               res;

  logic [ChAW-1:0]  ch_raddr, ch_waddr;
  logic [BlkAW-1:0] blk_addr;
  logic [SecAW-1:0] sec_addr;
  logic [ChEntW-1:0]  ch_rd, ch_wd;
  logic [CntEntW-1:0] blk_rd, blk_wd, sec_rd, sec_wd;
  logic mem_we_ch, mem_we_reg;
  logic in_range;
  logic [1:0] keep_marks;

  logic [ProdW-1:0] blk_prod, sec_prod;
  logic [IdxW-1:0]  blk_full, sec_full;
  assign in_range = 32'(channel) < NUM_CHANNELS;
  assign blk_prod = ProdW'(channel) * ProdW'(BlkMul);
  assign sec_prod = ProdW'(channel) * ProdW'(SecMul);
  assign blk_full = IdxW'(blk_prod >> BlkShift);
  assign sec_full = IdxW'(sec_prod >> SecShift);

  // sweep reads one entry ahead of the entry it writes back
  assign init_wr = init_cnt - 1'b1;

  always_comb begin
    if (state == S_INIT) begin
      ch_raddr = init_cnt[ChAW-1:0];
      ch_waddr = init_wr[ChAW-1:0];
      blk_addr = init_wr[BlkAW-1:0];
      sec_addr = init_wr[SecAW-1:0];
    end else begin
      ch_raddr = ChAW'(channel);
      ch_waddr = ChAW'(channel);
      blk_addr = blk_full[BlkAW-1:0];
      sec_addr = sec_full[SecAW-1:0];
    end
  end

  hdcf_counter_ram #(.DEPTH(NUM_CHANNELS), .WIDTH(ChEntW), .AW(ChAW)) u_ch_ram (
    .clk(clk),
    .rd_en(state == S_READ || (state == S_INIT && init_cnt != IdxW'(NUM_CHANNELS))),
    .rd_addr(ch_raddr), .rd_data(ch_rd),
    .wr_en(mem_we_ch), .wr_addr(ch_waddr), .wr_data(ch_wd)
  );
  hdcf_counter_ram #(.DEPTH(NumBlocks), .WIDTH(CntEntW), .AW(BlkAW)) u_blk_ram (
    .clk(clk), .rd_en(state == S_READ), .rd_addr(blk_addr), .rd_data(blk_rd),
    .wr_en(mem_we_reg && ({1'b0, init_wr} < (IdxW + 1)'(NumBlocks)
           || state != S_INIT)),
    .wr_addr(blk_addr), .wr_data(blk_wd)
  );
  hdcf_counter_ram #(.DEPTH(NumSectors), .WIDTH(CntEntW), .AW(SecAW)) u_sec_ram (
    .clk(clk), .rd_en(state == S_READ), .rd_addr(sec_addr), .rd_data(sec_rd),
    .wr_en(mem_we_reg && ({1'b0, init_wr} < (IdxW + 1)'(NumSectors)
           || state != S_INIT)),
    .wr_addr(sec_addr), .wr_data(sec_wd)
  );

  // counts as seen this run
  logic [COUNT_BITS-1:0] ch_cnt, blk_cnt, sec_cnt;
  logic s_hot, s_dead;
  assign ch_cnt  = (ch_rd[ChEntW-1 -: EpW] == epoch) ? ch_rd[COUNT_BITS-1:0] : '0;
  assign blk_cnt = (blk_rd[CntEntW-1 -: EpW] == epoch) ? blk_rd[COUNT_BITS-1:0] : '0;
  assign sec_cnt = (sec_rd[CntEntW-1 -: EpW] == epoch) ? sec_rd[COUNT_BITS-1:0] : '0;
  assign s_hot   = ch_rd[COUNT_BITS];
  assign s_dead  = ch_rd[COUNT_BITS+1];
  assign keep_marks = sweep_keep ? ch_rd[COUNT_BITS +: 2] : 2'b00;

  logic hit;
  assign hit = energy > $signed(ftype ? cfg.thr1 : cfg.thr0);

  // two products, one multiplier each
  logic [FractionW+COUNT_BITS-1:0] lim_ch, lim_rg;
  logic [FractionW+COUNT_BITS-1:0] lhs_ch, lhs_blk, lhs_sec;
  logic own_hot, blk_hot, sec_hot, hot, dead;
  assign lim_ch  = (ftype ? cfg.frac1 : cfg.frac0) * good_events;
  assign lim_rg  = cfg.fracr * good_events;
  assign lhs_ch  = {ch_cnt, 16'h0};
  assign lhs_blk = {blk_cnt, 16'h0};
  assign lhs_sec = {sec_cnt, 16'h0};
  assign own_hot = lhs_ch > lim_ch;
  assign blk_hot = lhs_blk > lim_rg;
  assign sec_hot = lhs_sec > lim_rg;
  assign hot     = own_hot || blk_hot || sec_hot;
  assign dead    = !own_hot && ch_cnt == '0;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  logic is_sample, is_eval;
  assign is_sample = kind == KIND_SAMPLE;
  assign is_eval   = kind == KIND_EVALUATE;

  // an in-range evaluate waits while the previous word is still unread
  logic mod_hold, out_valid_next;
  assign mod_hold = is_eval && in_range && out_ch.valid && !out_ch.ready;

  always_comb begin
    out_valid_next = out_ch.valid && !out_ch.ready;
    if (state == S_MOD && is_eval && in_range && !mod_hold) out_valid_next = 1'b1;
  end

  always_comb begin
    mem_we_ch  = 1'b0;
    mem_we_reg = 1'b0;
    ch_wd  = {epoch, 2'b00, ch_cnt};
    blk_wd = {epoch, blk_cnt};
    sec_wd = {epoch, sec_cnt};
    if (state == S_INIT) begin
      mem_we_ch  = init_cnt != '0;
      mem_we_reg = init_cnt != '0;
      ch_wd  = {{EpW{1'b0}}, keep_marks, {COUNT_BITS{1'b0}}};
      blk_wd = '0;
      sec_wd = '0;
    end else if (state == S_MOD && in_range && !mod_hold) begin
      if (is_sample && hit) begin
        mem_we_ch  = 1'b1;
        mem_we_reg = 1'b1;
        ch_wd  = {epoch, s_dead, s_hot, sat_inc(ch_cnt)};
        blk_wd = {epoch, sat_inc(blk_cnt)};
        sec_wd = {epoch, sat_inc(sec_cnt)};
      end else if (is_eval) begin
        mem_we_ch = 1'b1;
        ch_wd = {epoch, s_dead | dead, s_hot | hot, ch_cnt};
      end
    end
  end

  assign in_ch.ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_INIT;
      init_cnt        <= '0;
      sweep_keep      <= 1'b0;
      epoch           <= '0;
      good_events     <= '0;
      event_is_good   <= 1'b0;
      region_seen_hot <= 1'b0;
      out_ch.valid    <= 1'b0;
    end else begin
      out_ch.valid <= out_valid_next;
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == IdxW'(NUM_CHANNELS)) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          kind    <= in_ch.kind;
          channel <= in_ch.channel;
          ftype   <= in_ch.fiber;
          energy  <= in_ch.energy;
          state   <= S_READ;
        end
        S_READ: state <= S_MOD;
        S_MOD: if (!mod_hold) begin
          state <= S_OUT;
          case (kind_t'(kind))
            KIND_SAMPLE:
              if (in_range && hit && !ftype) event_is_good <= 1'b1;
            KIND_END_EVT: begin
              if (event_is_good) good_events <= sat_inc(good_events);
              event_is_good <= 1'b0;
            end
            KIND_CLEAR: begin
              // new epoch hides all old counts; wrap needs a real sweep
              epoch         <= epoch + 1'b1;
              good_events   <= '0;
              event_is_good <= 1'b0;
              if (epoch == '1) begin
                state      <= S_INIT;
                init_cnt   <= '0;
                sweep_keep <= 1'b1;
              end
            end
            KIND_EVALUATE: if (in_range) begin
              res.channel        <= channel;
              res.hot_now        <= hot;
              res.dead_now       <= dead;
              res.block_hot      <= blk_hot;
              res.sector_hot     <= sec_hot;
              res.ever_hot       <= s_hot | hot;
              res.ever_dead      <= s_dead | dead;
              res.any_region_hot <= region_seen_hot | blk_hot | sec_hot;
              region_seen_hot    <= region_seen_hot | blk_hot | sec_hot;
            end
            default: ;
          endcase
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.result_channel = res.channel;
  assign out_ch.hot_now        = res.hot_now;
  assign out_ch.dead_now       = res.dead_now;
  assign out_ch.block_hot      = res.block_hot;
  assign out_ch.sector_hot     = res.sector_hot;
  assign out_ch.ever_hot       = res.ever_hot;
  assign out_ch.ever_dead      = res.ever_dead;
  assign out_ch.any_region_hot = res.any_region_hot;
endmodule

// ===== rtl/hdcf_checker.sv =====
// ----------------------------------------------------------------------------
// hdcf_checker
// port-level checks of the hot and dead channel finder
// ----------------------------------------------------------------------------
module hdcf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic hot_now,
  input logic ever_hot,
  input logic dead_now,
  input logic ever_dead
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output word dropped");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second item taken in flight");
  a_word_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("word without a matching item");
  a_sticky_hot: assert property (@(posedge clk) disable iff (rst)
    out_valid && hot_now |-> ever_hot) else $error("hot without sticky mark");
  a_sticky_dead: assert property (@(posedge clk) disable iff (rst)
    out_valid && dead_now |-> ever_dead) else $error("dead without sticky mark");
endmodule

bind hot_dead_channel_finder hdcf_checker u_hdcf_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .hot_now(out_ch.hot_now),
  .ever_hot(out_ch.ever_hot), .dead_now(out_ch.dead_now),
  .ever_dead(out_ch.ever_dead)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hot and dead channel finder
// ----------------------------------------------------------------------------
// Items are queued by the stimulus process and fed to in_ch by a driver with
// random gaps. The channel counters, good-event count and sticky marks are
// kept alongside, and every word on out_ch is checked against the verdict
// predicted for the oldest pending evaluation. Runs in phases, with the
// thresholds and fractions rewritten while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import hdcf_pkg::*;

  localparam int NCH  = NumChannelsDef;
  localparam int NBLK = NCH / BlockSizeDef;
  localparam int NSEC = NCH / SectorSizeDef;
  localparam int unsigned CNT_MAX = (1 << CountBitsDef) - 1;

  typedef struct {
    kind_t                     kind;
    logic [ChannelW-1:0]       channel;
    logic                      fiber;
    logic signed [EnergyW-1:0] energy;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CfgAddrW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  hdcf_in_if  in_if ();
  hdcf_out_if out_if ();

  hot_dead_channel_finder dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // occupancy model
  int unsigned chan_hits [NCH];
  int unsigned blk_hits  [NBLK];
  int unsigned sec_hits  [NSEC];
  int unsigned good_evts;
  bit          evt_good;
  bit          ever_hot_mark  [NCH];
  bit          ever_dead_mark [NCH];
  bit          region_hot_seen;

  logic signed [EnergyW-1:0] thr0, thr1;
  logic [FractionW-1:0]      frac0, frac1, fracr;

  item_t   pending_items [$];
  result_t pending_verdicts [$];

  int  errors = 0;
  bit  word_taken = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  calm = 0;
  bit  long_hold_req = 0;
  bit  hold_done = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void clear_counts();
    foreach (chan_hits[i]) chan_hits[i] = 0;
    foreach (blk_hits[i]) blk_hits[i] = 0;
    foreach (sec_hits[i]) sec_hits[i] = 0;
    good_evts = 0;
    evt_good  = 0;
  endfunction

  function automatic int unsigned bump(int unsigned c);
    return (c < CNT_MAX) ? c + 1 : c;
  endfunction

  function automatic bit above_limit(int unsigned c, logic [FractionW-1:0] f);
    longint unsigned lhs, rhs;
    lhs = longint'(c) << 16;
    rhs = longint'(f) * longint'(good_evts);
    return lhs > rhs;
  endfunction

  function automatic void predict_item(item_t it);
    logic signed [EnergyW-1:0] thr;
    int unsigned ch, hits;
    bit own, blk, sec;
    result_t r;
    ch = 32'(it.channel);
    case (it.kind)
      KIND_SAMPLE: begin
        if (ch < NCH) begin
          thr = it.fiber ? thr1 : thr0;
          if (it.energy > thr) begin
            chan_hits[ch] = bump(chan_hits[ch]);
            blk_hits[ch / BlockSizeDef] = bump(blk_hits[ch / BlockSizeDef]);
            sec_hits[ch / SectorSizeDef] = bump(sec_hits[ch / SectorSizeDef]);
            if (!it.fiber) evt_good = 1;
          end
        end
      end
      KIND_END_EVT: begin
        if (evt_good) good_evts = bump(good_evts);
        evt_good = 0;
      end
      KIND_CLEAR: clear_counts();
      default: begin
        if (ch < NCH) begin
          hits = chan_hits[ch];
          own  = above_limit(hits, it.fiber ? frac1 : frac0);
          blk  = above_limit(blk_hits[ch / BlockSizeDef], fracr);
          sec  = above_limit(sec_hits[ch / SectorSizeDef], fracr);
          r.channel    = it.channel;
          r.hot_now    = own | blk | sec;
          r.dead_now   = !own && hits == 0;
          r.block_hot  = blk;
          r.sector_hot = sec;
          if (r.hot_now) ever_hot_mark[ch] = 1;
          if (r.dead_now) ever_dead_mark[ch] = 1;
          if (blk || sec) region_hot_seen = 1;
          r.ever_hot       = ever_hot_mark[ch];
          r.ever_dead      = ever_dead_mark[ch];
          r.any_region_hot = region_hot_seen;
          pending_verdicts.push_back(r);
        end
      end
    endcase
  endfunction

  // accepted words on both sides, sampled at the rising edge
  always @(posedge clk) begin
    result_t want;
    item_t   it;
    word_taken = !rst && in_if.valid && in_if.ready;
    if (word_taken) begin
      it.kind    = kind_t'(in_if.kind);
      it.channel = in_if.channel;
      it.fiber   = in_if.fiber;
      it.energy  = in_if.energy;
      predict_item(it);
    end
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected word, channel", int'(out_if.result_channel), -1);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_if.result_channel !== want.channel)
          report_mismatch("result_channel", int'(out_if.result_channel),
                          int'(want.channel));
        if (out_if.hot_now !== want.hot_now)
          report_mismatch("hot_now", int'(out_if.hot_now), int'(want.hot_now));
        if (out_if.dead_now !== want.dead_now)
          report_mismatch("dead_now", int'(out_if.dead_now), int'(want.dead_now));
        if (out_if.block_hot !== want.block_hot)
          report_mismatch("block_hot", int'(out_if.block_hot), int'(want.block_hot));
        if (out_if.sector_hot !== want.sector_hot)
          report_mismatch("sector_hot", int'(out_if.sector_hot), int'(want.sector_hot));
        if (out_if.ever_hot !== want.ever_hot)
          report_mismatch("ever_hot", int'(out_if.ever_hot), int'(want.ever_hot));
        if (out_if.ever_dead !== want.ever_dead)
          report_mismatch("ever_dead", int'(out_if.ever_dead), int'(want.ever_dead));
        if (out_if.any_region_hot !== want.any_region_hot)
          report_mismatch("any_region_hot", int'(out_if.any_region_hot),
                          int'(want.any_region_hot));
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    item_t it;
    if (!rst) begin
      if (in_if.valid && !word_taken) begin
        // word still on offer
      end else if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_if.kind       <= it.kind;
        in_if.channel    <= it.channel;
        in_if.fiber      <= it.fiber;
        in_if.energy     <= it.energy;
        in_if.valid      <= 1'b1;
        if (!calm && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 18);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (long_hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 300;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (!calm && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 18);
    end
  end

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_THR0:  thr0  = val;
      REG_THR1:  thr1  = val;
      REG_FRAC0: frac0 = val[FractionW-1:0];
      REG_FRAC1: frac1 = val[FractionW-1:0];
      default:   fracr = val[FractionW-1:0];
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_item(kind_t k, int ch, int ft, int en);
    item_t it;
    it.kind    = k;
    it.channel = ChannelW'(ch);
    it.fiber   = ft[0];
    it.energy  = EnergyW'(en);
    pending_items.push_back(it);
  endtask

  // wait until all words are in and out, then let any trailing item finish
  task automatic drain();
    while (pending_items.size() > 0 || in_if.valid || pending_verdicts.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom_range(NCH, 32767);
    if (r < 12) return $urandom_range(0, NCH - 1);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 64 + $urandom_range(0, 5);
      2: return 384 + $urandom_range(0, 3);
      default: return NCH - 1 - $urandom_range(0, 5);
    endcase
  endfunction

  task automatic add_random(int n);
    int r, en, ft;
    logic signed [EnergyW-1:0] t;
    repeat (n) begin
      r  = $urandom_range(0, 99);
      ft = $urandom_range(0, 1);
      t  = ft ? thr1 : thr0;
      if ($urandom_range(0, 1)) en = t + $urandom_range(0, 4) - 2;
      else en = $urandom_range(0, 262143);
      if (r < 55) add_item(KIND_SAMPLE, pick_channel(), ft, en);
      else if (r < 70) add_item(KIND_END_EVT, $urandom_range(0, 32767), ft, en);
      else if (r < 97) add_item(KIND_EVALUATE, pick_channel(), ft, en);
      else add_item(KIND_CLEAR, $urandom_range(0, 32767), ft, en);
    end
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_SAMPLE;
    in_if.channel    = '0;
    in_if.fiber      = 1'b0;
    in_if.energy     = '0;
    out_if.ready     = 1'b0;
    thr0 = '0; thr1 = '0; frac0 = 16'd32768; frac1 = 16'd32768; fracr = 16'd32768;
    foreach (ever_hot_mark[i]) begin
      ever_hot_mark[i]  = 0;
      ever_dead_mark[i] = 0;
    end
    region_hot_seen = 0;
    clear_counts();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at reset thresholds and halves
    write_reg(REG_THR0, 18'd0);
    write_reg(REG_THR1, 18'd0);
    write_reg(REG_FRAC0, 18'd32768);
    write_reg(REG_FRAC1, 18'd32768);
    write_reg(REG_FRACR, 18'd32768);
    add_item(KIND_EVALUATE, 5, 0, 0);          // nothing counted yet
    add_item(KIND_SAMPLE, 0, 0, 0);            // energy on threshold, no hit
    add_item(KIND_SAMPLE, 0, 0, 1);
    add_item(KIND_SAMPLE, 0, 1, 131071);
    add_item(KIND_SAMPLE, 0, 1, -131072);
    add_item(KIND_SAMPLE, NCH - 1, 1, 7);
    add_item(KIND_SAMPLE, NCH, 0, 100);        // out of range, ignored
    add_item(KIND_SAMPLE, 32767, 0, 100);
    add_item(KIND_END_EVT, 0, 0, 0);
    add_item(KIND_END_EVT, 0, 0, 0);           // event without a hit
    add_item(KIND_EVALUATE, 0, 0, 0);
    add_item(KIND_EVALUATE, 0, 0, 0);          // repeated evaluation
    add_item(KIND_EVALUATE, 1, 1, 0);          // dead in a hot block
    add_item(KIND_EVALUATE, NCH - 1, 1, 0);
    add_item(KIND_EVALUATE, NCH, 0, 0);
    add_item(KIND_EVALUATE, 32767, 1, 0);
    add_item(KIND_CLEAR, 0, 0, 0);
    add_item(KIND_EVALUATE, 0, 0, 0);          // sticky marks survive the clear
    add_item(KIND_SAMPLE, 700, 0, 3);
    add_item(KIND_END_EVT, 0, 0, 0);
    add_item(KIND_EVALUATE, 700, 0, 0);
    add_item(KIND_EVALUATE, 701, 1, 0);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p % 3)
        0: begin
          write_reg(REG_THR0, 18'h20000);
          write_reg(REG_THR1, 18'h1FFFF);
          write_reg(REG_FRAC0, 18'd0);
          write_reg(REG_FRAC1, 18'd65535);
          write_reg(REG_FRACR, 18'd65535);
        end
        1: begin
          write_reg(REG_THR0, CfgDataW'($urandom_range(0, 262143)));
          write_reg(REG_THR1, CfgDataW'($urandom_range(0, 262143)));
          write_reg(REG_FRAC0, CfgDataW'($urandom_range(0, 65535)));
          write_reg(REG_FRAC1, CfgDataW'($urandom_range(0, 65535)));
          write_reg(REG_FRACR, CfgDataW'($urandom_range(0, 65535)));
        end
        default: begin
          write_reg(REG_THR0, CfgDataW'($urandom_range(0, 400) - 200));
          write_reg(REG_THR1, CfgDataW'($urandom_range(0, 400) - 200));
          write_reg(REG_FRAC0, CfgDataW'($urandom_range(0, 3) << 14));
          write_reg(REG_FRAC1, 18'd65535);
          write_reg(REG_FRACR, 18'd0);
        end
      endcase
      if (p == 8) calm = 1;
      add_random(92);
      if (p == 3) begin
        // receiver stops for a long stretch while items keep coming
        long_hold_req = 1;
        add_random(20);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
